@@ sv/tfs_pkg.sv @@
`timescale 1ns / 1ps

package tfs_pkg;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_FILL  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] COLOUR_BLACK = 2'd0;
    localparam logic [1:0] COLOUR_RED   = 2'd1;

    localparam logic [1:0] CODE_BLACK = 2'b00;
    localparam logic [1:0] CODE_RED   = 2'b01;
    localparam logic [1:0] CODE_WHITE = 2'b11;

    localparam logic [7:0] PAT_BLACK = 8'h00;
    localparam logic [7:0] PAT_RED   = 8'h55;
    localparam logic [7:0] PAT_WHITE = 8'hFF;
    localparam logic [7:0] PAT_BEYOND = 8'h55;

    localparam logic [3:0] PANEL_BLACK = 4'h0;
    localparam logic [3:0] PANEL_RED   = 4'h4;
    localparam logic [3:0] PANEL_WHITE = 4'h3;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_CLIP,
        S_MUL,
        S_ADDR,
        S_MERGE,
        S_RD_WAIT,
        S_OUT_HI,
        S_OUT_LO
    } t_state;

    typedef struct packed {
        logic capture;
        logic fill_load;
        logic sweep_wr;
        logic clip;
        logic mul;
        logic addr;
        logic merge;
        logic load_out;
        logic out_lo;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] in_func;
        logic       rd_in_range;
        logic       sweep_last;
    } t_dp_sts;

    function automatic logic [1:0] pixel_code(input logic [1:0] colour);
        logic [1:0] code;
        unique case (colour)
            COLOUR_BLACK: code = CODE_BLACK;
            COLOUR_RED:   code = CODE_RED;
            default:      code = CODE_WHITE;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] fill_pattern(input logic [1:0] colour);
        logic [7:0] pat;
        unique case (colour)
            COLOUR_BLACK: pat = PAT_BLACK;
            COLOUR_RED:   pat = PAT_RED;
            default:      pat = PAT_WHITE;
        endcase
        return pat;
    endfunction

    function automatic logic [3:0] panel_code(input logic [1:0] pair);
        logic [3:0] pc;
        unique case (pair)
            CODE_BLACK: pc = PANEL_BLACK;
            CODE_RED:   pc = PANEL_RED;
            default:    pc = PANEL_WHITE;
        endcase
        return pc;
    endfunction

endpackage

@@ sv/tfs_ctrl.sv @@
`timescale 1ns / 1ps

module tfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_last,
    input  tfs_pkg::t_dp_sts  i_sts,
    output tfs_pkg::t_dp_cmd  o_cmd
);

    tfs_pkg::t_state r_state;
    tfs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfs_pkg::S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tfs_pkg::S_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = tfs_pkg::S_IDLE;
                end
            end
            tfs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_sts.in_func)
                        tfs_pkg::FUNC_WRITE: n_state = tfs_pkg::S_CLIP;
                        tfs_pkg::FUNC_FILL:  n_state = tfs_pkg::S_SWEEP;
                        tfs_pkg::FUNC_READ: begin
                            if (i_sts.rd_in_range) begin
                                n_state = tfs_pkg::S_RD_WAIT;
                            end
                        end
                        default: n_state = tfs_pkg::S_IDLE;
                    endcase
                end
            end
            tfs_pkg::S_CLIP:    n_state = tfs_pkg::S_MUL;
            tfs_pkg::S_MUL:     n_state = tfs_pkg::S_ADDR;
            tfs_pkg::S_ADDR:    n_state = tfs_pkg::S_MERGE;
            tfs_pkg::S_MERGE:   n_state = tfs_pkg::S_IDLE;
            tfs_pkg::S_RD_WAIT: n_state = tfs_pkg::S_OUT_HI;
            tfs_pkg::S_OUT_HI: begin
                if (!i_out_stall) begin
                    n_state = tfs_pkg::S_OUT_LO;
                end
            end
            tfs_pkg::S_OUT_LO: begin
                if (!i_out_stall) begin
                    n_state = tfs_pkg::S_IDLE;
                end
            end
            default: n_state = tfs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        o_last      = 1'b0;
        unique case (r_state)
            tfs_pkg::S_SWEEP: o_cmd.sweep_wr = 1'b1;
            tfs_pkg::S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
                o_cmd.fill_load = i_in_valid && (i_sts.in_func == tfs_pkg::FUNC_FILL);
            end
            tfs_pkg::S_CLIP:    o_cmd.clip = 1'b1;
            tfs_pkg::S_MUL:     o_cmd.mul = 1'b1;
            tfs_pkg::S_ADDR:    o_cmd.addr = 1'b1;
            tfs_pkg::S_MERGE:   o_cmd.merge = 1'b1;
            tfs_pkg::S_RD_WAIT: o_cmd.load_out = 1'b1;
            tfs_pkg::S_OUT_HI:  o_out_valid = 1'b1;
            tfs_pkg::S_OUT_LO: begin
                o_out_valid  = 1'b1;
                o_last       = 1'b1;
                o_cmd.out_lo = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

`ifndef ASSERT_OFF
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request taken while a result is pending");

    a_hi_then_lo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_last) |=> (o_out_valid && o_last))
        else $error("second byte of a read did not follow the first");

    a_lo_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last) |=> !o_in_stall)
        else $error("not ready after the last byte of a read");

    a_sweep_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep_wr |-> (o_in_stall && !o_out_valid))
        else $error("store sweep overlaps a request or result");
`endif

endmodule

@@ sv/tfs_datapath.sv @@
`timescale 1ns / 1ps

module tfs_datapath #(
    parameter int PANEL_WIDTH  = 640,
    parameter int PANEL_HEIGHT = 384,
    parameter int OUT_BYTES    = 61440
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [1:0]         i_colour,
    input  logic [15:0]        i_byte_index,
    input  tfs_pkg::t_dp_cmd   i_cmd,
    output tfs_pkg::t_dp_sts   o_sts,
    output logic [7:0]         o_panel_byte
);

    localparam int STORE_BYTES = PANEL_WIDTH * PANEL_HEIGHT / 4;
    localparam int AW   = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int MAXD = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CW   = $clog2(MAXD);
    localparam int WW   = $clog2(PANEL_WIDTH + 1);
    localparam int PRW  = CW + WW;

    localparam logic [16:0]    W17      = 17'(PANEL_WIDTH);
    localparam logic [16:0]    H17      = 17'(PANEL_HEIGHT);
    localparam logic [16:0]    OUT17    = 17'(OUT_BYTES);
    localparam logic [31:0]    STORE32  = 32'(STORE_BYTES);
    localparam logic [CW-1:0]  W_M1     = CW'(PANEL_WIDTH - 1);
    localparam logic [CW-1:0]  H_M1     = CW'(PANEL_HEIGHT - 1);
    localparam logic [PRW-1:0] W_PR     = PRW'(PANEL_WIDTH);
    localparam logic [PRW-1:0] STORE_PR = PRW'(STORE_BYTES);
    localparam logic [AW-1:0]  LAST_A   = AW'(STORE_BYTES - 1);

    logic [7:0] mem [STORE_BYTES];

    logic [1:0]         r_rot;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic [1:0]         r_colour;
    logic               r_rd_store;
    logic [AW-1:0]      r_sweep_cnt;
    logic [7:0]         r_fill_pat;
    logic [CW-1:0]      r_px;
    logic [CW-1:0]      r_py;
    logic               r_ok;
    logic [PRW-1:0]     r_prod;
    logic [AW-1:0]      r_wa;
    logic               r_wok;
    logic [1:0]         r_sub;
    logic [7:0]         r_rd_data;
    logic [7:0]         r_hi;
    logic [7:0]         r_lo;

    logic               in_store;
    logic [AW-1:0]      in_addr;
    logic [16:0]        lw;
    logic [16:0]        lh;
    logic               clip_ok;
    logic [CW-1:0]      xc;
    logic [CW-1:0]      yc;
    logic [CW-1:0]      px;
    logic [CW-1:0]      py;
    logic [PRW-1:0]     pix_idx;
    logic               pix_ok;
    logic [AW-1:0]      pix_addr;
    logic [AW-1:0]      rd_addr;
    logic [2:0]         shamt;
    logic [7:0]         merged;
    logic [7:0]         src_byte;
    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [7:0]         mem_wd;

    assign in_store = {16'd0, i_byte_index} < STORE32;
    assign in_addr  = in_store ? AW'(i_byte_index) : '0;

    assign o_sts.in_func     = i_func;
    assign o_sts.rd_in_range = {1'b0, i_byte_index} < OUT17;
    assign o_sts.sweep_last  = (r_sweep_cnt == LAST_A);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot <= 2'd0;
        end else if (i_cfg_we) begin
            r_rot <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_x        <= i_pos_x;
            r_y        <= i_pos_y;
            r_colour   <= i_colour;
            r_rd_store <= in_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
            r_fill_pat  <= tfs_pkg::PAT_WHITE;
        end else if (i_cmd.fill_load) begin
            r_sweep_cnt <= '0;
            r_fill_pat  <= tfs_pkg::fill_pattern(i_colour);
        end else if (i_cmd.sweep_wr) begin
            r_sweep_cnt <= (r_sweep_cnt == LAST_A) ? '0 : r_sweep_cnt + AW'(1);
        end
    end

    assign lw = r_rot[0] ? H17 : W17;
    assign lh = r_rot[0] ? W17 : H17;
    assign clip_ok = !r_x[15] && !r_y[15]
                     && ({2'b00, r_x[14:0]} < lw) && ({2'b00, r_y[14:0]} < lh);
    assign xc = r_x[CW-1:0];
    assign yc = r_y[CW-1:0];

    always_comb begin
        unique case (r_rot)
            2'd1: begin
                px = W_M1 - yc;
                py = xc;
            end
            2'd2: begin
                px = W_M1 - xc;
                py = H_M1 - yc;
            end
            2'd3: begin
                px = yc;
                py = H_M1 - xc;
            end
            default: begin
                px = xc;
                py = yc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clip) begin
            r_px <= px;
            r_py <= py;
            r_ok <= clip_ok;
        end
        if (i_cmd.mul) begin
            r_prod <= {{WW{1'b0}}, r_py} * W_PR;
        end
    end

    assign pix_idx  = PRW'(r_px >> 2) + (r_prod >> 2);
    assign pix_ok   = r_ok && (pix_idx < STORE_PR);
    assign pix_addr = pix_ok ? pix_idx[AW-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.addr) begin
            r_wa  <= pix_addr;
            r_wok <= pix_ok;
            r_sub <= r_px[1:0];
        end
    end

    assign shamt  = {~r_sub, 1'b0};
    assign merged = (r_rd_data & ~(8'h03 << shamt))
                    | (8'(tfs_pkg::pixel_code(r_colour)) << shamt);

    assign rd_addr = i_cmd.addr ? pix_addr : in_addr;
    assign mem_we  = i_cmd.sweep_wr || (i_cmd.merge && r_wok);
    assign mem_wa  = i_cmd.sweep_wr ? r_sweep_cnt : r_wa;
    assign mem_wd  = i_cmd.sweep_wr ? r_fill_pat : merged;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign src_byte = r_rd_store ? r_rd_data : tfs_pkg::PAT_BEYOND;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_hi <= {tfs_pkg::panel_code(src_byte[7:6]), tfs_pkg::panel_code(src_byte[5:4])};
            r_lo <= {tfs_pkg::panel_code(src_byte[3:2]), tfs_pkg::panel_code(src_byte[1:0])};
        end
    end

    assign o_panel_byte = i_cmd.out_lo ? r_lo : r_hi;

endmodule

@@ sv/tricolor_frame_store.sv @@
`timescale 1ns / 1ps

// Frame store for a three-color panel, 2 bits per pixel, four pixels a byte.
// Request channel: i_in_valid / o_in_stall with i_func, i_pos_x, i_pos_y,
// i_colour, i_byte_index. Result channel: o_out_valid / i_out_stall with
// o_panel_byte and o_last. Rotation is set through i_cfg_we / i_cfg_data.
// One request is worked at a time; o_in_stall is high until it finishes.
// Pixel write: each request goes through take, clip and rotate, row multiply,
// address and store read, merge write; no result.
// Fill: one store byte per cycle over all W*H/4 store bytes, no result.
// Read: the store byte is read as the request is taken; the first byte is
// offered after the read-wait state, the second right after the first is
// taken. A read at or past OUT_BYTES gives no result and ends as it is taken.
// Reset: after i_rst_n rises the store is swept to white, one byte per cycle
// over all PANEL_WIDTH*PANEL_HEIGHT/4 bytes, with o_in_stall high; rotation is 0.
// When the receiver stalls, the current result byte holds and no new request
// is taken until both bytes have been delivered.
module tricolor_frame_store #(
    parameter int PANEL_WIDTH  = 640,
    parameter int PANEL_HEIGHT = 384,
    parameter int OUT_BYTES    = 61440
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [1:0]         i_colour,
    input  logic [15:0]        i_byte_index,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_panel_byte,
    output logic               o_last
);

    tfs_pkg::t_dp_cmd cmd;
    tfs_pkg::t_dp_sts sts;

    tfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_last      (o_last),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    tfs_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .OUT_BYTES    (OUT_BYTES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_colour     (i_colour),
        .i_byte_index (i_byte_index),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_panel_byte (o_panel_byte)
    );

endmodule

@@ verif/tfs_checker.sv @@
`timescale 1ns / 1ps

module tfs_checker #(
    parameter int PANEL_WIDTH  = 640,
    parameter int PANEL_HEIGHT = 384,
    parameter int OUT_BYTES    = 61440
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [1:0]         i_colour,
    input  logic [15:0]        i_byte_index,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [7:0]         i_panel_byte,
    input  logic               i_last,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int STORE_BYTES = (PANEL_WIDTH * PANEL_HEIGHT) / 4;

    typedef struct {
        logic [7:0] panel_byte;
        logic       last;
    } t_panel_out;

    logic [7:0] frame_mem [STORE_BYTES];
    logic [1:0] rotation;
    t_panel_out readout_q [$];
    t_panel_out oldest;
    int         fails = 0;

    function automatic logic [3:0] panel_nibble(input logic [1:0] pair);
        case (pair)
            tfs_pkg::CODE_BLACK: return tfs_pkg::PANEL_BLACK;
            tfs_pkg::CODE_RED:   return tfs_pkg::PANEL_RED;
            default:             return tfs_pkg::PANEL_WHITE;
        endcase
    endfunction

    function automatic void paint_pixel(input int x, input int y, input logic [1:0] colour);
        int lw;
        int lh;
        int px;
        int py;
        int idx;
        int sh;
        logic [1:0] code;
        lw = rotation[0] ? PANEL_HEIGHT : PANEL_WIDTH;
        lh = rotation[0] ? PANEL_WIDTH : PANEL_HEIGHT;
        if (x < 0 || x >= lw || y < 0 || y >= lh) return;
        case (rotation)
            2'd1: begin
                px = PANEL_WIDTH - y - 1;
                py = x;
            end
            2'd2: begin
                px = PANEL_WIDTH - x - 1;
                py = PANEL_HEIGHT - y - 1;
            end
            2'd3: begin
                px = y;
                py = PANEL_HEIGHT - x - 1;
            end
            default: begin
                px = x;
                py = y;
            end
        endcase
        if (px < 0 || py < 0) return;
        idx = px / 4 + (py * PANEL_WIDTH) / 4;
        if (idx >= STORE_BYTES) return;
        sh = 2 * (3 - (px % 4));
        if (colour == tfs_pkg::COLOUR_BLACK) code = tfs_pkg::CODE_BLACK;
        else if (colour == tfs_pkg::COLOUR_RED) code = tfs_pkg::CODE_RED;
        else code = tfs_pkg::CODE_WHITE;
        frame_mem[idx][sh +: 2] = code;
    endfunction

    function automatic void fill_store(input logic [7:0] pat);
        foreach (frame_mem[i]) frame_mem[i] = pat;
    endfunction

    function automatic void predict_request();
        logic [7:0] b;
        logic [7:0] pat;
        case (i_func)
            tfs_pkg::FUNC_WRITE: paint_pixel(i_pos_x, i_pos_y, i_colour);
            tfs_pkg::FUNC_FILL: begin
                if (i_colour == tfs_pkg::COLOUR_BLACK) pat = tfs_pkg::PAT_BLACK;
                else if (i_colour == tfs_pkg::COLOUR_RED) pat = tfs_pkg::PAT_RED;
                else pat = tfs_pkg::PAT_WHITE;
                fill_store(pat);
            end
            tfs_pkg::FUNC_READ: begin
                if (int'(i_byte_index) < OUT_BYTES) begin
                    b = (int'(i_byte_index) < STORE_BYTES) ? frame_mem[i_byte_index]
                                                          : tfs_pkg::PAT_BEYOND;
                    readout_q.push_back('{{panel_nibble(b[7:6]), panel_nibble(b[5:4])}, 1'b0});
                    readout_q.push_back('{{panel_nibble(b[3:2]), panel_nibble(b[1:0])}, 1'b1});
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill_store(tfs_pkg::PAT_WHITE);
            rotation = 2'd0;
            readout_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (readout_q.size() == 0) begin
                    $error("unexpected result: panel_byte %02h last %0b", i_panel_byte, i_last);
                    fails++;
                end else begin
                    oldest = readout_q.pop_front();
                    if (i_panel_byte !== oldest.panel_byte) begin
                        $error("panel_byte mismatch: expected %02h, actual %02h",
                               oldest.panel_byte, i_panel_byte);
                        fails++;
                    end
                    if (i_last !== oldest.last) begin
                        $error("last mismatch: expected %0b, actual %0b", oldest.last, i_last);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) rotation = i_cfg_data;
            if (i_in_valid && !i_in_stall) predict_request();
        end
        o_pending    <= readout_q.size();
        o_fail_count <= fails;
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int PW = 640;
    localparam int PH = 384;
    localparam int OB = 61440;
    localparam int ROW_BYTES = PW / 4;
    localparam int WATCHDOG_LIMIT = 250000;
    localparam int PHASE_ITEMS = 150;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_data = 2'd0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_func = tfs_pkg::FUNC_WRITE;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic [1:0]         i_colour = tfs_pkg::COLOUR_BLACK;
    logic [15:0]        i_byte_index = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [7:0]         o_panel_byte;
    logic               o_last;

    int         fail_count;
    int         pending;
    int         phase = 0;
    logic [1:0] cur_rot = 2'd0;
    int         fills_left = 3;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    tricolor_frame_store #(
        .PANEL_WIDTH(PW),
        .PANEL_HEIGHT(PH),
        .OUT_BYTES(OB)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_colour(i_colour),
        .i_byte_index(i_byte_index),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_panel_byte(o_panel_byte),
        .o_last(o_last)
    );

    tfs_checker #(
        .PANEL_WIDTH(PW),
        .PANEL_HEIGHT(PH),
        .OUT_BYTES(OB)
    ) checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall),
        .i_func(i_func),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_colour(i_colour),
        .i_byte_index(i_byte_index),
        .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_panel_byte(o_panel_byte),
        .i_last(o_last),
        .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // hold off once for a long stretch in phase 1 to back up the request side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (phase == 1 && !hold_done && o_out_valid) begin
            hold_done = 1'b1;
            hold_left = 400;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= (phase != 3) && ($urandom_range(99) < 21);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic offer(input logic [1:0] f, input logic signed [15:0] x,
                         input logic signed [15:0] y, input logic [1:0] c,
                         input logic [15:0] idx);
        while (phase != 2 && $urandom_range(99) < 21) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_func       <= f;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_colour     <= c;
        i_byte_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic set_rotation(input logic [1:0] r);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= r;
        cur_rot = r;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] corner_byte();
        int row;
        int col;
        row = $urandom_range(1) ? $urandom_range(15) : PH - 1 - $urandom_range(15);
        col = $urandom_range(1) ? $urandom_range(3) : ROW_BYTES - 1 - $urandom_range(3);
        return 16'(row * ROW_BYTES + col);
    endfunction

    task automatic random_request();
        int lw;
        int lh;
        int pick;
        int x;
        int y;
        lw = cur_rot[0] ? PH : PW;
        lh = cur_rot[0] ? PW : PH;
        pick = $urandom_range(999);
        if (pick < 450) begin
            x = $urandom_range(1) ? $urandom_range(15) : lw - 1 - $urandom_range(15);
            y = $urandom_range(1) ? $urandom_range(15) : lh - 1 - $urandom_range(15);
            offer(tfs_pkg::FUNC_WRITE, 16'(x), 16'(y), 2'($urandom_range(3)), 16'($urandom));
        end else if (pick < 520) begin
            case ($urandom_range(3))
                0: x = -1;
                1: x = 0;
                2: x = lw - 1;
                default: x = lw;
            endcase
            case ($urandom_range(3))
                0: y = -1;
                1: y = 0;
                2: y = lh - 1;
                default: y = lh;
            endcase
            offer(tfs_pkg::FUNC_WRITE, 16'(x), 16'(y), 2'($urandom_range(3)), 16'($urandom));
        end else if (pick < 560) begin
            offer(tfs_pkg::FUNC_WRITE, 16'($urandom), 16'($urandom), 2'($urandom_range(3)),
                  16'($urandom));
        end else if (pick < 900) begin
            offer(tfs_pkg::FUNC_READ, 16'($urandom), 16'($urandom), 2'($urandom_range(3)),
                  corner_byte());
        end else if (pick < 950) begin
            offer(tfs_pkg::FUNC_READ, 16'($urandom), 16'($urandom), 2'($urandom_range(3)),
                  16'($urandom));
        end else if (pick < 990) begin
            offer(FUNC_UNUSED, 16'($urandom), 16'($urandom), 2'($urandom_range(3)),
                  16'($urandom));
        end else if (fills_left > 0) begin
            fills_left--;
            offer(tfs_pkg::FUNC_FILL, 16'($urandom), 16'($urandom), 2'($urandom_range(3)),
                  16'($urandom));
        end else begin
            offer(tfs_pkg::FUNC_READ, 16'($urandom), 16'($urandom), 2'($urandom_range(3)),
                  corner_byte());
        end
    endtask

    initial begin : stimulus
        logic [1:0] rots [5];
        rots = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd1};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_rotation(rots[0]);

        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'sd1, 16'sd0, tfs_pkg::COLOUR_RED, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'sd2, 16'sd0, 2'd2, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'sd3, 16'sd0, 2'd3, 16'd0);
        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'(PW - 1), 16'(PH - 1), tfs_pkg::COLOUR_RED, 16'd0);
        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'(OB - 1));
        offer(tfs_pkg::FUNC_WRITE, -16'sd1, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'(PW), 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'sd0, 16'(PH), tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'sd0, -16'sd1, tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'h8000, 16'h7FFF, tfs_pkg::COLOUR_RED, 16'd0);
        offer(tfs_pkg::FUNC_WRITE, 16'h7FFF, 16'h8000, tfs_pkg::COLOUR_RED, 16'd0);
        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'(OB));
        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'hFFFF);
        offer(FUNC_UNUSED, 16'sd5, 16'sd5, tfs_pkg::COLOUR_RED, 16'd0);
        offer(tfs_pkg::FUNC_FILL, 16'sd0, 16'sd0, tfs_pkg::COLOUR_RED, 16'd0);
        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd5);
        offer(tfs_pkg::FUNC_FILL, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd7);
        offer(tfs_pkg::FUNC_FILL, 16'sd0, 16'sd0, 2'd3, 16'd0);
        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'd100);
        offer(tfs_pkg::FUNC_WRITE, 16'sd4, 16'sd1, tfs_pkg::COLOUR_BLACK, 16'd0);
        offer(tfs_pkg::FUNC_READ, 16'sd0, 16'sd0, tfs_pkg::COLOUR_BLACK, 16'(ROW_BYTES + 1));

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) set_rotation(rots[ph]);
            phase <= ph;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 4 && k == PHASE_ITEMS / 2) drain();
                random_request();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
sv/tfs_pkg.sv
sv/tfs_ctrl.sv
sv/tfs_datapath.sv
sv/tricolor_frame_store.sv
verif/tfs_checker.sv
verif/tb_top.sv
